// ----- design/rle_bgra_line_decoder_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the run-length BGRA line decoder
// Shared concurrent check forms, synchronous reset masks each check.
// ----------------------------------------------------------------------------
`ifndef RLE_BGRA_LINE_DECODER_UNIT_ASSERT_SVH
`define RLE_BGRA_LINE_DECODER_UNIT_ASSERT_SVH

// same-cycle implication
`define RBLD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RBLD_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/rbld_pkg.sv -----
// ----------------------------------------------------------------------------
// rbld_pkg
// Shared types of the run-length BGRA line decoder.
// ----------------------------------------------------------------------------
package rbld_pkg;

  typedef struct packed {
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [7:0]  alpha;
    logic [10:0] repeat_count;
    logic        line_end;
  } result_t;

  // queue status reported by the queue to the top level
  typedef struct packed {
    logic full;
    logic not_empty;
  } q_status_t;

endpackage

// ----- design/rbld_parser.sv -----
// ----------------------------------------------------------------------------
// rbld_parser
// Front part: takes one compressed byte per cycle while fire is high, tracks
// alignment, run headers, pad bytes and pixel gathering, and issues at most one run word per byte.
// ----------------------------------------------------------------------------
module rbld_parser #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [12:0]         line_width,
  input  logic                fire,
  input  logic [7:0]          data_byte,
  input  logic                line_start,
  output logic                res_valid,
  output rbld_pkg::result_t   res
);

  localparam int          PL_W   = $clog2(MAX_WIDTH + 1);
  localparam logic [12:0] MAX_13 = 13'(MAX_WIDTH);

  localparam logic [2:0] KIND_LIT3 = 3'd2;
  localparam logic [2:0] KIND_VAL3 = 3'd3;
  localparam logic [2:0] KIND_LIT4 = 3'd4;
  localparam logic [2:0] KIND_VAL4 = 3'd5;

  typedef enum logic [2:0] {
    PH_HDR_LO, PH_HDR_HI, PH_PAD, PH_LIT3, PH_VAL3, PH_LIT4, PH_VAL4
  } phase_t;

  phase_t            phase, phase_next;
  logic              parity, parity_next;
  logic [PL_W-1:0]   pixels_left, pixels_left_next;
  logic [10:0]       run_left, run_left_next;
  logic [2:0]        run_kind, run_kind_next;
  logic [1:0]        pad_left, pad_left_next;
  logic [1:0]        byte_in_pixel, byte_in_pixel_next;
  logic [23:0]       gathered, gathered_next;

  logic              res_hit;
  rbld_pkg::result_t res_c;
  logic              do_enter;
  logic              par;
  logic [10:0]       hdr_cnt;
  logic [10:0]       cnt;
  logic              last;
  logic              wide_px;
  logic [1:0]        need;

  always_comb begin
    phase_next         = phase;
    parity_next        = parity;
    pixels_left_next   = pixels_left;
    run_left_next      = run_left;
    run_kind_next      = run_kind;
    pad_left_next      = pad_left;
    byte_in_pixel_next = byte_in_pixel;
    gathered_next      = gathered;
    res_hit            = 1'b0;
    res_c              = '0;
    do_enter           = 1'b0;
    par                = 1'b0;
    hdr_cnt            = {data_byte[2:0], gathered[7:0]};
    cnt                = '0;
    last               = 1'b0;
    wide_px            = (phase == PH_LIT4) || (phase == PH_VAL4);
    need               = wide_px ? 2'd3 : 2'd2;

    // new line: abort any run, restart at offset zero
    if (line_start) begin
      pixels_left_next   = (line_width > MAX_13) ? PL_W'(MAX_WIDTH) : PL_W'(line_width);
      parity_next        = 1'b0;
      run_kind_next      = '0;
      pad_left_next      = '0;
      phase_next         = PH_HDR_LO;
      run_left_next      = '0;
      byte_in_pixel_next = '0;
      gathered_next      = '0;
    end

    if (!(phase_next == PH_HDR_LO && pixels_left_next == '0)) begin
      par         = parity_next;
      parity_next = ~parity_next;
      case (phase_next)
        PH_HDR_LO: begin
          // drop the filler byte at an odd offset
          if (!par) begin
            gathered_next = {16'd0, data_byte};
            phase_next    = PH_HDR_HI;
          end
        end
        PH_HDR_HI: begin
          hdr_cnt = {data_byte[2:0], gathered_next[7:0]};
          if ({2'b00, hdr_cnt} > 13'(pixels_left_next)) begin
            cnt = 11'(pixels_left_next);
          end else begin
            cnt = hdr_cnt;
          end
          run_kind_next      = data_byte[7:5];
          pad_left_next      = data_byte[4:3];
          pixels_left_next   = pixels_left_next - PL_W'(cnt);
          run_left_next      = cnt;
          gathered_next      = '0;
          byte_in_pixel_next = '0;
          if (data_byte[4:3] != 2'd0) begin
            phase_next = PH_PAD;
          end else begin
            do_enter = 1'b1;
          end
        end
        PH_PAD: begin
          pad_left_next = pad_left_next - 2'd1;
          if (pad_left_next == 2'd0) begin
            do_enter = 1'b1;
          end
        end
        PH_LIT3, PH_VAL3, PH_LIT4, PH_VAL4: begin
          if (byte_in_pixel_next < need) begin
            gathered_next = gathered_next | (24'(data_byte) << {byte_in_pixel_next, 3'b000});
            byte_in_pixel_next = byte_in_pixel_next + 2'd1;
          end else begin
            if (wide_px) begin
              res_c.alpha = gathered_next[7:0];
              res_c.blue  = gathered_next[15:8];
              res_c.green = gathered_next[23:16];
            end else begin
              res_c.blue  = gathered_next[7:0];
              res_c.green = gathered_next[15:8];
              res_c.alpha = 8'hff;
            end
            res_c.red          = data_byte;
            byte_in_pixel_next = '0;
            gathered_next      = '0;
            if (phase_next == PH_LIT3 || phase_next == PH_LIT4) begin
              run_left_next = run_left_next - 11'd1;
              last          = (run_left_next == 11'd0);
              if (last) begin
                phase_next = PH_HDR_LO;
              end
              res_hit            = 1'b1;
              res_c.repeat_count = 11'd1;
              res_c.line_end     = last && (pixels_left_next == '0);
            end else begin
              cnt           = run_left_next;
              run_left_next = '0;
              phase_next    = PH_HDR_LO;
              res_hit            = (cnt != 11'd0);
              res_c.repeat_count = cnt;
              res_c.line_end     = (pixels_left_next == '0);
            end
          end
        end
        default: begin
          run_left_next      = '0;
          byte_in_pixel_next = '0;
          gathered_next      = '0;
          phase_next         = PH_HDR_LO;
        end
      endcase

      // header and pads done: start the data part of the run
      if (do_enter) begin
        byte_in_pixel_next = '0;
        gathered_next      = '0;
        case (run_kind_next)
          KIND_LIT3: begin
            if (run_left_next == 11'd0) begin
              phase_next = PH_HDR_LO;
            end else begin
              phase_next = PH_LIT3;
            end
          end
          KIND_VAL3: begin
            phase_next = PH_VAL3;
          end
          KIND_LIT4: begin
            if (run_left_next == 11'd0) begin
              phase_next = PH_HDR_LO;
            end else begin
              phase_next = PH_LIT4;
            end
          end
          KIND_VAL4: begin
            phase_next = PH_VAL4;
          end
          default: begin
            // skipped pixels come out as zeros right away
            cnt                = run_left_next;
            run_left_next      = '0;
            phase_next         = PH_HDR_LO;
            res_hit            = (cnt != 11'd0);
            res_c              = '0;
            res_c.repeat_count = cnt;
            res_c.line_end     = (pixels_left_next == '0);
          end
        endcase
      end
    end
  end

  assign res_valid = fire && res_hit;
  assign res       = res_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HDR_LO;
      parity        <= 1'b0;
      pixels_left   <= '0;
      run_left      <= '0;
      run_kind      <= '0;
      pad_left      <= '0;
      byte_in_pixel <= '0;
      gathered      <= '0;
    end else if (fire) begin
      phase         <= phase_next;
      parity        <= parity_next;
      pixels_left   <= pixels_left_next;
      run_left      <= run_left_next;
      run_kind      <= run_kind_next;
      pad_left      <= pad_left_next;
      byte_in_pixel <= byte_in_pixel_next;
      gathered      <= gathered_next;
    end
  end

endmodule

// ----- design/rbld_fifo.sv -----
// ----------------------------------------------------------------------------
// rbld_fifo
// Short run-word queue between the parser and the output stage.
// ----------------------------------------------------------------------------
module rbld_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr,
  input  rbld_pkg::result_t     wr_data,
  input  logic                  rd,
  output rbld_pkg::result_t     rd_data,
  output rbld_pkg::q_status_t   status
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  rbld_pkg::result_t mem [DEPTH];
  logic [AW-1:0]     wr_ptr;
  logic [AW-1:0]     rd_ptr;
  logic [CW-1:0]     count;

  assign rd_data          = mem[rd_ptr];
  assign status.full      = (count == CW'(DEPTH));
  assign status.not_empty = (count != '0);

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({wr, rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- design/rbld_out.sv -----
// ----------------------------------------------------------------------------
// rbld_out
// Back part: holds the oldest run word on the result ports until popped.
// ----------------------------------------------------------------------------
module rbld_out (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  rbld_pkg::result_t   q_data,
  output logic                q_take,
  input  logic                pop,
  output logic                empty,
  output rbld_pkg::result_t   word
);

  logic              out_valid;
  rbld_pkg::result_t out_data;

  // refill when the slot is free or drains this cycle
  assign q_take = q_valid && (!out_valid || pop);
  assign empty  = !out_valid;
  assign word   = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_take) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_take) begin
      out_data <= q_data;
    end
  end

endmodule

// ----- design/rle_bgra_line_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// rle_bgra_line_decoder_unit
// Run-length BGRA line decoder: compressed bytes in, pixel run words out.
// Input queue side: push a byte with data_byte/line_start while full is low;
// line_start marks the first byte of a line. Result side: a run word sits on
// blue/green/red/alpha/repeat_count/line_end while empty is low; pop takes it.
// line_width is written through cfg_valid/cfg_data (cfg_ready is always high)
// while the block is idle, a rule for the user that the block does not enforce;
// values above MAX_WIDTH saturate at line start. Throughput: one byte per
// cycle while full is low. The word of a run-ending byte passes the queue,
// then the out stage, to the result ports. When pop stays low the output stage
// and the QUEUE_DEPTH-entry queue fill; full then rises and holds the byte side until a word is popped.
// Reset empties the queue and output stage, sets line_width to 640 and
// leaves no line open: bytes are dropped until one carries line_start.
// ----------------------------------------------------------------------------
`include "rle_bgra_line_decoder_unit_assert.svh"

module rle_bgra_line_decoder_unit #(
  parameter int MAX_WIDTH   = 4096,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  input  logic        line_start,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  blue,
  output logic [7:0]  green,
  output logic [7:0]  red,
  output logic [7:0]  alpha,
  output logic [10:0] repeat_count,
  output logic        line_end,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [12:0] cfg_data
);

  logic [12:0]         line_width;
  logic                fire;
  logic                res_valid;
  rbld_pkg::result_t   res;
  rbld_pkg::result_t   q_data;
  rbld_pkg::q_status_t q_stat;
  logic                q_take;
  rbld_pkg::result_t   word;

  assign cfg_ready = 1'b1;
  assign full      = q_stat.full;
  assign fire      = push && !q_stat.full;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= 13'd640;
    end else if (cfg_valid) begin
      line_width <= cfg_data;
    end
  end

  rbld_parser #(.MAX_WIDTH(MAX_WIDTH)) u_parser (
    .clk        (clk),
    .rst        (rst),
    .line_width (line_width),
    .fire       (fire),
    .data_byte  (data_byte),
    .line_start (line_start),
    .res_valid  (res_valid),
    .res        (res)
  );

  rbld_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr      (res_valid),
    .wr_data (res),
    .rd      (q_take),
    .rd_data (q_data),
    .status  (q_stat)
  );

  rbld_out u_out (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_stat.not_empty),
    .q_data  (q_data),
    .q_take  (q_take),
    .pop     (pop),
    .empty   (empty),
    .word    (word)
  );

  assign blue         = word.blue;
  assign green        = word.green;
  assign red          = word.red;
  assign alpha        = word.alpha;
  assign repeat_count = word.repeat_count;
  assign line_end     = word.line_end;

  `RBLD_ASSERT_IMP(a_count_nonzero, clk, rst, !empty, repeat_count != 11'd0, "empty run word")
  `RBLD_ASSERT_NXT(a_queue_feeds_out, clk, rst, q_stat.not_empty && empty, !empty, "word stuck")
  `RBLD_ASSERT_IMP(a_no_write_when_full, clk, rst, q_stat.full, !res_valid, "queue overrun")

endmodule
